// ===== hw/rtl/gsd_pkg.sv =====
`default_nettype none

package gsd_pkg;

   localparam int GSD_WINDOW_LIMIT = 1024;
   localparam int LANES            = 3;

   localparam int RAW_W      = 16;
   localparam int SCALED_W   = RAW_W + 1;
   localparam int OFF_W      = 18;
   localparam int CORR_W     = 19;
   localparam int SPAN_W     = CORR_W + 1;
   localparam int LEN_W      = 11;
   localparam int MARGIN_W   = 12;
   localparam int LIMIT_W    = MARGIN_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int OFFSET_LIMIT = 65536;

   localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RESET = 11'd100;
   localparam logic [MARGIN_W-1:0] THRESHOLD_RESET     = 12'd0;
   localparam logic [MARGIN_W-1:0] MARGIN_X_RESET      = 12'd120;
   localparam logic [MARGIN_W-1:0] MARGIN_Y_RESET      = 12'd260;
   localparam logic [MARGIN_W-1:0] MARGIN_Z_RESET      = 12'd380;

   typedef logic signed [RAW_W-1:0]    gsd_raw_type;
   typedef logic signed [SCALED_W-1:0] gsd_scaled_type;
   typedef logic signed [OFF_W-1:0]    gsd_offset_type;
   typedef logic signed [CORR_W-1:0]   gsd_corr_type;
   typedef logic [MARGIN_W-1:0]        gsd_margin_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 3'd0,
      CSR_THRESHOLD     = 3'd1,
      CSR_CALIBRATE     = 3'd2,
      CSR_MARGIN_X      = 3'd3,
      CSR_MARGIN_Y      = 3'd4,
      CSR_MARGIN_Z      = 3'd5
   } gsd_csr_index_type;

   typedef struct packed {
      logic load;
      logic adv2;
      logic adv3;
      logic first;
      logic wr_off;
   } gsd_lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic window_end;
      logic calibrate;
   } gsd_merge_ctrl_type;

   typedef struct packed {
      logic free;
      logic wr_off;
   } gsd_merge_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gsd_channels.sv =====
`default_nettype none

interface gsd_req_if import gsd_pkg::*; ();
   logic        valid;
   logic        ready;
   gsd_raw_type raw_x;
   gsd_raw_type raw_y;
   gsd_raw_type raw_z;

   modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
   modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface gsd_rsp_if import gsd_pkg::*; ();
   logic         valid;
   logic         ready;
   gsd_corr_type corrected_x;
   gsd_corr_type corrected_y;
   gsd_corr_type corrected_z;
   logic         window_end;
   logic         is_quiet;
   logic         offsets_updated;

   modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
                   output window_end, output is_quiet, output offsets_updated, input ready);
   modport sink   (input valid, input corrected_x, input corrected_y, input corrected_z,
                   input window_end, input is_quiet, input offsets_updated, output ready);
endinterface

interface gsd_csr_if import gsd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gsd_lane.sv =====
`default_nettype none

module gsd_lane import gsd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gsd_lane_ctrl_type ctrl,
   input  wire gsd_raw_type       raw,
   input  wire logic              flip,
   input  wire gsd_margin_type    threshold,
   input  wire gsd_margin_type    margin,
   output gsd_corr_type           corr,
   output logic                   quiet
);

   localparam logic signed [SPAN_W-1:0] OFF_MAX = SPAN_W'(OFFSET_LIMIT);
   localparam logic signed [SPAN_W-1:0] OFF_MIN = -SPAN_W'(OFFSET_LIMIT);

   gsd_scaled_type scaled_ff, scaled_in;
   gsd_corr_type   corr2_ff, corr2_in;
   gsd_corr_type   corr3_ff;
   gsd_corr_type   max_ff, min_ff;
   gsd_offset_type offset_ff, offset_in;

   gsd_raw_type              raw_sel;
   logic signed [SPAN_W-1:0] span, sum, half, noff, limit_s;
   logic [LIMIT_W-1:0]       limit;

   always_comb begin
      raw_sel   = flip ? -raw : raw;
      scaled_in = $signed({raw_sel, 1'b0});
      corr2_in  = CORR_W'(scaled_ff) + CORR_W'(offset_ff);
   end

   // window close: span check and new offset from the midpoint
   always_comb begin
      span    = SPAN_W'(max_ff) - SPAN_W'(min_ff);
      limit   = LIMIT_W'({1'b0, threshold} + {1'b0, margin}) << 1;
      limit_s = $signed(SPAN_W'(limit));
      quiet   = span < limit_s;
      sum     = SPAN_W'(max_ff) + SPAN_W'(min_ff);
      half    = $signed(sum + {{(SPAN_W-1){1'b0}}, sum[SPAN_W-1]}) >>> 1;
      noff    = -half;
      if (noff > OFF_MAX) begin
         offset_in = OFF_W'(OFF_MAX);
      end else if (noff < OFF_MIN) begin
         offset_in = OFF_W'(OFF_MIN);
      end else begin
         offset_in = OFF_W'(noff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (ctrl.wr_off) begin
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         scaled_ff <= scaled_in;
      end
      if (ctrl.adv2) begin
         corr2_ff <= corr2_in;
      end
      if (ctrl.adv3) begin
         corr3_ff <= corr2_ff;
         if (ctrl.first) begin
            max_ff <= corr2_ff;
            min_ff <= corr2_ff;
         end else begin
            if (corr2_ff > max_ff) begin
               max_ff <= corr2_ff;
            end
            if (corr2_ff < min_ff) begin
               min_ff <= corr2_ff;
            end
         end
      end
   end

   assign corr = corr3_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gsd_merge.sv =====
`default_nettype none

module gsd_merge import gsd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire gsd_merge_ctrl_type ctrl,
   input  wire gsd_corr_type       corr [LANES],
   input  wire logic [LANES-1:0]   quiet,
   output gsd_merge_stat_type      stat,
   gsd_rsp_if.source               rsp
);

   logic         valid_ff;
   gsd_corr_type corr_ff [LANES];
   logic         end_ff, quiet_ff, upd_ff;
   logic         quiet_all, upd;

   always_comb begin
      quiet_all   = ctrl.window_end && (&quiet);
      upd         = quiet_all && ctrl.calibrate;
      stat.free   = !valid_ff || rsp.ready;
      stat.wr_off = ctrl.load && upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         corr_ff  <= corr;
         end_ff   <= ctrl.window_end;
         quiet_ff <= quiet_all;
         upd_ff   <= upd;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.corrected_x     = corr_ff[0];
   assign rsp.corrected_y     = corr_ff[1];
   assign rsp.corrected_z     = corr_ff[2];
   assign rsp.window_end      = end_ff;
   assign rsp.is_quiet        = quiet_ff;
   assign rsp.offsets_updated = upd_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gyro_stillness_detector_core.sv =====
// Gyro stillness detector. Takes one three-axis sample per transfer and returns one
// offset-corrected sample per transfer, with window_end, is_quiet and offsets_updated
// flags on the sample that closes a window. Three axis lanes run side by side and a
// merge stage combines their span checks and holds the output register. Throughput is
// one sample per clock unless rsp back-pressure or a calibration hold stalls it. When
// calibration is enabled, the sample after a window-closing one waits in the first
// stage for the rewritten offsets from the merge stage. Configuration writes take
// effect at once and are meant to be made while no sample is in flight.
`default_nettype none

module gyro_stillness_detector_core import gsd_pkg::*; #(
   parameter int WINDOW_LIMIT = GSD_WINDOW_LIMIT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gsd_req_if.sink    req_chan,
   gsd_rsp_if.source  rsp_chan,
   gsd_csr_if.sink    csr_chan
);

   localparam int CntW = $clog2(WINDOW_LIMIT);
   localparam int LimW = $clog2(WINDOW_LIMIT + 1);
   localparam int EffW = ((LimW > LEN_W) ? LimW : LEN_W) + 1;

   logic [LEN_W-1:0]  window_length_ff;
   gsd_margin_type    threshold_ff;
   logic              calibrate_ff;
   gsd_margin_type    margin_ff [LANES];

   logic [CntW-1:0]   count_ff, count_in;
   logic [EffW-1:0]   wl_ext, eff_len, count_inc;
   logic              at_end;

   logic v1_ff, v2_ff, v3_ff;
   logic first1_ff, end1_ff, first2_ff, end2_ff, end3_ff;
   logic en1, en2, en3, en4, hazard;

   gsd_lane_ctrl_type  lane_ctrl;
   gsd_merge_ctrl_type merge_ctrl;
   gsd_merge_stat_type merge_stat;
   gsd_raw_type        lane_raw [LANES];
   gsd_corr_type       lane_corr [LANES];
   logic [LANES-1:0]   lane_quiet;
   logic [LANES-1:0]   lane_flip;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         threshold_ff     <= THRESHOLD_RESET;
         calibrate_ff     <= 1'b0;
         margin_ff[0]     <= MARGIN_X_RESET;
         margin_ff[1]     <= MARGIN_Y_RESET;
         margin_ff[2]     <= MARGIN_Z_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_chan.data[LEN_W-1:0];
            CSR_THRESHOLD:     threshold_ff     <= csr_chan.data;
            CSR_CALIBRATE:     calibrate_ff     <= csr_chan.data[0];
            CSR_MARGIN_X:      margin_ff[0]     <= csr_chan.data;
            CSR_MARGIN_Y:      margin_ff[1]     <= csr_chan.data;
            CSR_MARGIN_Z:      margin_ff[2]     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // window position
   always_comb begin
      wl_ext = EffW'(window_length_ff);
      if (window_length_ff == '0) begin
         eff_len = EffW'(1);
      end else if (wl_ext > EffW'(WINDOW_LIMIT)) begin
         eff_len = EffW'(WINDOW_LIMIT);
      end else begin
         eff_len = wl_ext;
      end
      count_inc = EffW'(count_ff) + EffW'(1);
      at_end    = count_inc >= eff_len;
      count_in  = at_end ? '0 : count_inc[CntW-1:0];
   end

   // pipeline control
   always_comb begin
      en4    = v3_ff && merge_stat.free;
      en3    = v2_ff && (!v3_ff || en4);
      hazard = calibrate_ff && ((v2_ff && end2_ff) || (v3_ff && end3_ff));
      en2    = v1_ff && (!v2_ff || en3) && !hazard;
      en1    = req_chan.valid && req_chan.ready;
   end

   assign req_chan.ready = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (en1) begin
            count_ff <= count_in;
         end
         if (en1) begin
            v1_ff <= 1'b1;
         end else if (en2) begin
            v1_ff <= 1'b0;
         end
         if (en2) begin
            v2_ff <= 1'b1;
         end else if (en3) begin
            v2_ff <= 1'b0;
         end
         if (en3) begin
            v3_ff <= 1'b1;
         end else if (en4) begin
            v3_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         first1_ff <= (count_ff == '0);
         end1_ff   <= at_end;
      end
      if (en2) begin
         first2_ff <= first1_ff;
         end2_ff   <= end1_ff;
      end
      if (en3) begin
         end3_ff <= end2_ff;
      end
   end

   always_comb begin
      lane_ctrl.load   = en1;
      lane_ctrl.adv2   = en2;
      lane_ctrl.adv3   = en3;
      lane_ctrl.first  = first2_ff;
      lane_ctrl.wr_off = merge_stat.wr_off;

      merge_ctrl.load       = en4;
      merge_ctrl.window_end = end3_ff;
      merge_ctrl.calibrate  = calibrate_ff;

      lane_raw[0] = req_chan.raw_x;
      lane_raw[1] = req_chan.raw_y;
      lane_raw[2] = req_chan.raw_z;
      lane_flip   = 3'b011;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      gsd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .raw       (lane_raw[g]),
         .flip      (lane_flip[g]),
         .threshold (threshold_ff),
         .margin    (margin_ff[g]),
         .corr      (lane_corr[g]),
         .quiet     (lane_quiet[g])
      );
   end

   gsd_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctrl  (merge_ctrl),
      .corr  (lane_corr),
      .quiet (lane_quiet),
      .stat  (merge_stat),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/gsd_checker.sv =====
`default_nettype none

module gsd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic window_end,
   input wire logic is_quiet,
   input wire logic offsets_updated
);

   logic [2:0] pend_ff;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         pend_ff <= pend_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pend_ff <= pend_ff - 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pend_ff != 3'd0)
      else $error("rsp transfer without a pending req");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more samples in flight than pipeline stages");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (offsets_updated || is_quiet) |-> window_end)
      else $error("quiet or update flag outside a window end");

endmodule

bind gyro_stillness_detector_core gsd_checker u_gsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .window_end      (rsp_chan.window_end),
   .is_quiet        (rsp_chan.is_quiet),
   .offsets_updated (rsp_chan.offsets_updated)
);

`default_nettype wire
